### hw/rtl/fit_policy_block_allocator_macros.svh
// assertion macros for the fit policy block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define FPBA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define FPBA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/fpba_pkg.sv
package fpba_pkg;

   // fixed field widths of the ports
   localparam int OPERATION_WIDTH   = 1;
   localparam int BLOCK_INDEX_WIDTH = 4;
   localparam int FIELD_SIZE_WIDTH  = 16;
   localparam int RESULT_CODE_WIDTH = 2;
   localparam int POLICY_WIDTH      = 2;
   localparam int COUNT_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 5;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIT_POLICY  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COUNT = 1'b1;

   // reset values
   localparam logic [POLICY_WIDTH-1:0] POLICY_RESET = 2'd0;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = 5'd16;

   // operations
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef enum logic [POLICY_WIDTH-1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_BEST  = 2'd1,
      POLICY_WORST = 2'd2
   } policy_type;

   typedef enum logic [RESULT_CODE_WIDTH-1:0] {
      CODE_ALLOCATED = 2'd0,
      CODE_NO_FIT    = 2'd1,
      CODE_LOADED    = 2'd2
   } result_code_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic                    clear;
      logic                    entry_valid;
      logic [POLICY_WIDTH-1:0] policy;
   } scan_ctrl_type;

endpackage

### hw/rtl/fit_policy_block_allocator.sv
// Block allocator with a table of free space per memory block, placing requests by first,
// best or worst fit. A load transaction writes one block's size at acceptance, then posts its
// result. A request transaction reads the active blocks one a cycle through the single read
// port of the table into one shared compare unit, in steps: acceptance, the scan, the last
// read, and the write-back with the result. The input is stalled while a transaction is in
// flight; a result waits in the output register until taken, and the next transaction may
// be accepted meanwhile. Table entries are undefined until loaded.
module fit_policy_block_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [fpba_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [fpba_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [fpba_pkg::OPERATION_WIDTH-1:0]     req_operation,
   input  logic [fpba_pkg::BLOCK_INDEX_WIDTH-1:0]   req_block_index,
   input  logic [fpba_pkg::FIELD_SIZE_WIDTH-1:0]    req_size_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [fpba_pkg::RESULT_CODE_WIDTH-1:0]   rsp_result_code,
   output logic [fpba_pkg::BLOCK_INDEX_WIDTH-1:0]   rsp_chosen_block,
   output logic [fpba_pkg::FIELD_SIZE_WIDTH-1:0]    rsp_space_left
);
   import fpba_pkg::*;

`include "fit_policy_block_allocator_macros.svh"

   localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_MAX   = (MAX_BLOCKS > 31) ? 31 : MAX_BLOCKS;
   localparam int SW        = SIZE_WIDTH;
   localparam int FW        = FIELD_SIZE_WIDTH;
   localparam int BW        = BLOCK_INDEX_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // configuration
   logic [POLICY_WIDTH-1:0] policy_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;

   // sequencer and registered outputs
   state_type                state_ff, state_in;
   logic [COUNT_WIDTH-1:0]   ptr_ff, ptr_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     op_ff, op_in;
   logic [SW-1:0]            want_ff, want_in;
   logic [BW-1:0]            ld_blk_ff, ld_blk_in;
   logic [FW-1:0]            ld_left_ff, ld_left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RESULT_CODE_WIDTH-1:0] rsp_code_ff, rsp_code_in;
   logic [BW-1:0]            rsp_blk_ff, rsp_blk_in;
   logic [FW-1:0]            rsp_left_ff, rsp_left_in;

   // datapath
   logic                     accept;
   logic                     post;
   logic [COUNT_WIDTH-1:0]   n_raw;
   logic [COUNT_WIDTH-1:0]   n_act;
   logic [SW+FW-1:0]         size_ext;
   logic [SW-1:0]            size_int;
   logic [FW+SW-1:0]         size_out_ext;
   logic                     load_in_range;
   logic [IDX_W+BW-1:0]      load_addr_ext;
   logic [IDX_W+COUNT_WIDTH-1:0] ptr_addr_ext;
   logic [IDX_W-1:0]         read_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [SW-1:0]            mem_wdata;
   logic [SW-1:0]            mem_rdata;
   logic [SW-1:0]            remain;
   logic [FW+SW-1:0]         remain_ext;
   logic [BW+IDX_W-1:0]      pick_ext;
   logic                     load_we;
   logic                     wb_we;
   scan_ctrl_type            scan_ctrl;
   logic                     hit;
   logic [IDX_W-1:0]         pick_idx;
   logic [SW-1:0]            pick_val;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FIT_POLICY:  policy_ff <= csr_write_data[POLICY_WIDTH-1:0];
            CSR_BLOCK_COUNT: count_ff  <= csr_write_data[COUNT_WIDTH-1:0];
            default:         ;
         endcase
      end
   end

   // active block count, clamped to one and to the table depth
   always_comb begin
      n_raw = (count_ff == '0) ? COUNT_WIDTH'(1) : count_ff;
      n_act = (n_raw > COUNT_WIDTH'(CNT_MAX)) ? COUNT_WIDTH'(CNT_MAX) : n_raw;
   end

   // size and index conversions
   always_comb begin
      size_ext      = {{SW{1'b0}}, req_size_value};
      size_int      = size_ext[SW-1:0];
      size_out_ext  = {{FW{1'b0}}, size_int};
      load_in_range = (32'(req_block_index) < MAX_BLOCKS);
      load_addr_ext = {{IDX_W{1'b0}}, req_block_index};
      ptr_addr_ext  = {{IDX_W{1'b0}}, ptr_ff};
      read_addr     = ptr_addr_ext[IDX_W-1:0];
      remain        = pick_val - want_ff;
      remain_ext    = {{FW{1'b0}}, remain};
      pick_ext      = {{BW{1'b0}}, pick_idx};
   end

   assign accept = req_valid && !req_stall;
   assign post   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // table write port: loads at acceptance, write-back when the result is posted
   always_comb begin
      load_we   = accept && (req_operation == OP_LOAD) && load_in_range;
      wb_we     = post && (op_ff == OP_REQUEST) && hit;
      mem_we    = load_we || wb_we;
      mem_waddr = load_we ? load_addr_ext[IDX_W-1:0] : pick_idx;
      mem_wdata = load_we ? size_int : remain;
   end

   // compare unit control
   always_comb begin
      scan_ctrl.clear       = accept;
      scan_ctrl.entry_valid = rd_valid_ff;
      scan_ctrl.policy      = policy_ff;
   end

   fpba_mem #(
      .DEPTH      (MAX_BLOCKS),
      .DATA_WIDTH (SW),
      .ADDR_WIDTH (IDX_W)
   ) u_mem (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (mem_waddr),
      .write_data   (mem_wdata),
      .read_addr    (read_addr),
      .read_data    (mem_rdata)
   );

   fpba_scan #(
      .SIZE_WIDTH (SW),
      .IDX_WIDTH  (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .entry_idx (rd_idx_ff),
      .entry_val (mem_rdata),
      .want      (want_ff),
      .hit       (hit),
      .pick_idx  (pick_idx),
      .pick_val  (pick_val)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      op_in        = op_ff;
      want_in      = want_ff;
      ld_blk_in    = ld_blk_ff;
      ld_left_in   = ld_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_left_in  = rsp_left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_operation;
               want_in    = size_int;
               ld_blk_in  = req_block_index;
               ld_left_in = load_in_range ? size_out_ext[FW-1:0] : '0;
               ptr_in     = '0;
               state_in   = (req_operation == OP_REQUEST) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_idx_in   = read_addr;
            ptr_in      = ptr_ff + COUNT_WIDTH'(1);
            if (ptr_ff == n_act - COUNT_WIDTH'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (post) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_LOAD) begin
                  rsp_code_in = CODE_LOADED;
                  rsp_blk_in  = ld_blk_ff;
                  rsp_left_in = ld_left_ff;
               end else if (hit) begin
                  rsp_code_in = CODE_ALLOCATED;
                  rsp_blk_in  = pick_ext[BW-1:0];
                  rsp_left_in = remain_ext[FW-1:0];
               end else begin
                  rsp_code_in = CODE_NO_FIT;
                  rsp_blk_in  = '0;
                  rsp_left_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      op_ff       <= op_in;
      want_ff     <= want_in;
      ld_blk_ff   <= ld_blk_in;
      ld_left_ff  <= ld_left_in;
      rsp_code_ff <= rsp_code_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_left_ff <= rsp_left_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_code  = rsp_code_ff;
   assign rsp_chosen_block = rsp_blk_ff;
   assign rsp_space_left   = rsp_left_ff;

   // checks
   `FPBA_ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == ST_SCAN, ptr_ff < n_act)
   `FPBA_ASSERT_NEXT(a_request_scans, clock, reset, accept && (req_operation == OP_REQUEST), state_ff == ST_SCAN)
   `FPBA_ASSERT_IMPLIES(a_code_known, clock, reset, rsp_valid, (rsp_result_code == CODE_ALLOCATED) || (rsp_result_code == CODE_NO_FIT) || (rsp_result_code == CODE_LOADED))
   `FPBA_ASSERT_IMPLIES(a_no_fit_zero, clock, reset, rsp_valid && (rsp_result_code == CODE_NO_FIT), (rsp_chosen_block == '0) && (rsp_space_left == '0))

endmodule

### hw/rtl/fpba_mem.sv
module fpba_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 16,
   parameter int ADDR_WIDTH = 4
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_addr,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  logic [ADDR_WIDTH-1:0] read_addr,
   output logic [DATA_WIDTH-1:0] read_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] read_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### hw/rtl/fpba_scan.sv
module fpba_scan #(
   parameter int SIZE_WIDTH = 16,
   parameter int IDX_WIDTH  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fpba_pkg::scan_ctrl_type       ctrl,
   input  logic [IDX_WIDTH-1:0]          entry_idx,
   input  logic [SIZE_WIDTH-1:0]         entry_val,
   input  logic [SIZE_WIDTH-1:0]         want,
   output logic                          hit,
   output logic [IDX_WIDTH-1:0]          pick_idx,
   output logic [SIZE_WIDTH-1:0]         pick_val
);
   import fpba_pkg::*;

   logic                  found_ff;
   logic                  found_in;
   logic [IDX_WIDTH-1:0]  pick_idx_ff;
   logic [SIZE_WIDTH-1:0] pick_val_ff;
   logic                  fits;
   logic                  larger;
   logic                  smaller;
   logic                  take;
   logic                  take_eff;

   // compare of one table entry against the request and the current pick
   always_comb begin
      fits    = (want <= entry_val);
      larger  = (entry_val > pick_val_ff);
      smaller = (entry_val < pick_val_ff);
      case (policy_type'(ctrl.policy))
         POLICY_WORST: take = !found_ff || larger;
         POLICY_BEST:  take = fits && (!found_ff || smaller);
         POLICY_FIRST: take = fits && !found_ff;
         default:      take = fits && !found_ff;
      endcase
      take_eff = ctrl.entry_valid && take;
      found_in = ctrl.clear ? 1'b0 : (found_ff || take_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // current pick
   always_ff @(posedge clock) begin
      if (take_eff) begin
         pick_idx_ff <= entry_idx;
         pick_val_ff <= entry_val;
      end
   end

   // worst fit still has to check the size; for the others it always holds
   assign hit      = found_ff && (want <= pick_val_ff);
   assign pick_idx = pick_idx_ff;
   assign pick_val = pick_val_ff;

endmodule

### tb/sv/fit_policy_block_allocator_test.sv
module fit_policy_block_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fpba_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int MAX_GAP      = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 25;
   localparam int PHASES       = 14;
   localparam int PHASE_ITEMS  = 75;
   localparam int FIXED_PHASES = 6;
   localparam int N_ROWS       = 22;

   // policy code the block does not name; it must act as first fit
   localparam logic [POLICY_WIDTH-1:0] POLICY_SPARE = 2'd3;

   typedef struct packed {
      result_code_type                 code;
      logic [BLOCK_INDEX_WIDTH-1:0]    block;
      logic [FIELD_SIZE_WIDTH-1:0]     left;
   } placement_type;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_POLICY,
      ROW_COUNT
   } row_kind_type;

   // one line of the directed sequence; config rows carry the value in size
   typedef struct packed {
      row_kind_type                    kind;
      logic                            op;
      logic [BLOCK_INDEX_WIDTH-1:0]    idx;
      logic [FIELD_SIZE_WIDTH-1:0]     size;
      logic                            typed;
      placement_type                   result;
   } stim_row_type;

   localparam placement_type NONE = '{CODE_ALLOCATED, 4'd0, 16'd0};

   // directed sequence: four blocks, every policy, ties, zero and full-size requests
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{ROW_COUNT,  OP_LOAD,    4'd0,  16'd4,      1'b0, NONE},
      '{ROW_ITEM,   OP_LOAD,    4'd0,  16'd100,    1'b1, '{CODE_LOADED, 4'd0, 16'd100}},
      '{ROW_ITEM,   OP_LOAD,    4'd1,  16'd30,     1'b1, '{CODE_LOADED, 4'd1, 16'd30}},
      '{ROW_ITEM,   OP_LOAD,    4'd2,  16'hFFFF,   1'b1, '{CODE_LOADED, 4'd2, 16'hFFFF}},
      '{ROW_ITEM,   OP_LOAD,    4'd3,  16'd0,      1'b1, '{CODE_LOADED, 4'd3, 16'd0}},
      '{ROW_POLICY, OP_LOAD,    4'd0,  {14'd0, POLICY_FIRST}, 1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd15, 16'd40,     1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd0,      1'b0, NONE},
      '{ROW_POLICY, OP_LOAD,    4'd0,  {14'd0, POLICY_BEST}, 1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd7,  16'd30,     1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd0,      1'b0, NONE},
      '{ROW_POLICY, OP_LOAD,    4'd0,  {14'd0, POLICY_WORST}, 1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'hFFFF,   1'b1, '{CODE_ALLOCATED, 4'd2, 16'd0}},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'hFFFF,   1'b1, '{CODE_NO_FIT, 4'd0, 16'd0}},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd0,      1'b0, NONE},
      '{ROW_POLICY, OP_LOAD,    4'd0,  {14'd0, POLICY_SPARE}, 1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd1,      1'b0, NONE},
      '{ROW_COUNT,  OP_LOAD,    4'd0,  16'd0,      1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd60,     1'b0, NONE},
      '{ROW_ITEM,   OP_REQUEST, 4'd0,  16'd59,     1'b0, NONE},
      '{ROW_ITEM,   OP_LOAD,    4'd9,  16'd500,    1'b1, '{CODE_LOADED, 4'd9, 16'd500}},
      '{ROW_ITEM,   OP_LOAD,    4'd15, 16'h5A5A,   1'b1, '{CODE_LOADED, 4'd15, 16'h5A5A}}
   };

   // settings for the first random phases: every policy and the count extremes
   localparam logic [POLICY_WIDTH-1:0] PHASE_POLICY [FIXED_PHASES] = '{
      POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE, POLICY_BEST, POLICY_WORST
   };
   localparam logic [COUNT_WIDTH-1:0] PHASE_COUNT [FIXED_PHASES] = '{
      5'd16, 5'd1, 5'd31, 5'd0, 5'd16, 5'd17
   };

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0]     csr_index;
   logic [CSR_DATA_WIDTH-1:0]      csr_write_data;
   logic                           req_valid;
   logic                           req_stall;
   logic [OPERATION_WIDTH-1:0]     req_operation;
   logic [BLOCK_INDEX_WIDTH-1:0]   req_block_index;
   logic [FIELD_SIZE_WIDTH-1:0]    req_size_value;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [RESULT_CODE_WIDTH-1:0]   rsp_result_code;
   logic [BLOCK_INDEX_WIDTH-1:0]   rsp_chosen_block;
   logic [FIELD_SIZE_WIDTH-1:0]    rsp_space_left;

   // shadow of the free-space table and the two registers
   logic [FIELD_SIZE_WIDTH-1:0]    free_space [TABLE_DEPTH];
   logic [POLICY_WIDTH-1:0]        fit_setting;
   logic [COUNT_WIDTH-1:0]         count_setting;

   placement_type                  expected_placements [$];

   int                             max_gap;
   int                             cycle_count;
   int                             mismatch_count;
   int                             item_total;
   int                             setting_count;
   int                             alloc_seen;
   int                             nofit_seen;
   int                             load_seen;

   fit_policy_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_size_value   (req_size_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_code  (rsp_result_code),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_space_left   (rsp_space_left)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // blocks actually scanned: zero counts as one, anything above the table saturates
   function automatic int unsigned blocks_in_use();
      int unsigned n;
      n = 32'(count_setting);
      if (n == 0) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
   endfunction

   // shadow table update and expected outcome of one accepted transaction
   task automatic predict_placement(input logic op, input logic [3:0] idx,
                                    input logic [15:0] size, output placement_type res);
      int          pick;
      int unsigned n;
      n = blocks_in_use();
      pick = -1;
      res = '{CODE_NO_FIT, 4'd0, 16'd0};
      if (op == OP_LOAD) begin
         free_space[idx] = size;
         res = '{CODE_LOADED, idx, size};
      end else begin
         if (fit_setting == POLICY_WORST) begin
            // largest block, lowest index on a tie, then the fit check
            pick = 0;
            for (int j = 1; j < n; j++)
               if (free_space[j] > free_space[pick]) pick = j;
            if (free_space[pick] < size) pick = -1;
         end else if (fit_setting == POLICY_BEST) begin
            for (int j = 0; j < n; j++)
               if (size <= free_space[j] && (pick < 0 || free_space[j] < free_space[pick]))
                  pick = j;
         end else begin
            // first fit, also taken by the spare policy code
            for (int j = 0; j < n; j++)
               if (pick < 0 && size <= free_space[j]) pick = j;
         end
         if (pick >= 0) begin
            free_space[pick] = free_space[pick] - size;
            res = '{CODE_ALLOCATED, pick[3:0], free_space[pick]};
         end
      end
   endtask

   // drive one transaction after a random gap, then queue what it should return
   task automatic issue_transaction(input logic op, input logic [3:0] idx,
                                    input logic [15:0] size, input logic typed,
                                    input placement_type typed_res);
      int            gap;
      placement_type res;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_block_index <= idx;
      req_size_value  <= size;
      do @(posedge clock); while (req_stall);
      predict_placement(op, idx, size, res);
      expected_placements.push_back(typed ? typed_res : res);
      item_total++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic hold_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FIT_POLICY) fit_setting = data[POLICY_WIDTH-1:0];
      else count_setting = data;
   endtask

   // result side: random stall before each transaction
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         hold = (max_gap == 0) ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         case (rsp_result_code)
            CODE_ALLOCATED: alloc_seen++;
            CODE_NO_FIT:    nofit_seen++;
            default:        load_seen++;
         endcase
         if (expected_placements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: code %0d block %0d left %h",
                        rsp_result_code, rsp_chosen_block, rsp_space_left);
         end else begin
            want = expected_placements.pop_front();
            if (rsp_result_code !== want.code || rsp_chosen_block !== want.block ||
                rsp_space_left !== want.left) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected code %0d block %0d left %h, got %0d %0d %h",
                           want.code, want.block, want.left,
                           rsp_result_code, rsp_chosen_block, rsp_space_left);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_placements.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic                        op;
      logic [BLOCK_INDEX_WIDTH-1:0] idx;
      logic [FIELD_SIZE_WIDTH-1:0]  size;
      logic [FIELD_SIZE_WIDTH-1:0]  room;
      logic [POLICY_WIDTH-1:0]      pol;
      logic [COUNT_WIDTH-1:0]       cnt;
      int unsigned                  target;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_LOAD;
      req_block_index  = '0;
      req_size_value   = '0;
      max_gap          = MAX_GAP;
      cycle_count      = 0;
      mismatch_count   = 0;
      item_total       = 0;
      setting_count    = 0;
      alloc_seen       = 0;
      nofit_seen       = 0;
      load_seen        = 0;
      fit_setting      = POLICY_RESET;
      count_setting    = COUNT_RESET;
      for (int j = 0; j < TABLE_DEPTH; j++) free_space[j] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sequence
      for (int row = 0; row < N_ROWS; row++) begin
         case (DIRECTED_ROWS[row].kind)
            ROW_POLICY: begin
               hold_sender();
               write_register(CSR_FIT_POLICY, DIRECTED_ROWS[row].size[CSR_DATA_WIDTH-1:0]);
               setting_count++;
            end
            ROW_COUNT: begin
               hold_sender();
               write_register(CSR_BLOCK_COUNT, DIRECTED_ROWS[row].size[CSR_DATA_WIDTH-1:0]);
               setting_count++;
            end
            default: begin
               issue_transaction(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].idx,
                                 DIRECTED_ROWS[row].size, DIRECTED_ROWS[row].typed,
                                 DIRECTED_ROWS[row].result);
            end
         endcase
      end

      // fill the whole table so any block count only reads loaded blocks
      for (int j = 0; j < TABLE_DEPTH; j++)
         issue_transaction(OP_LOAD, j[3:0], FIELD_SIZE_WIDTH'($urandom), 1'b0, NONE);

      // random phases, each under one register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         hold_sender();
         if (phase < FIXED_PHASES) begin
            pol = PHASE_POLICY[phase];
            cnt = PHASE_COUNT[phase];
         end else begin
            pol = POLICY_WIDTH'($urandom_range(0, 3));
            cnt = COUNT_WIDTH'($urandom_range(0, 31));
         end
         write_register(CSR_FIT_POLICY, {3'b000, pol});
         write_register(CSR_BLOCK_COUNT, cnt);
         setting_count++;
         // every fourth phase runs back to back on both sides
         max_gap = (phase % 4 == 3) ? 0 : MAX_GAP;

         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 25) begin
               op  = OP_LOAD;
               idx = BLOCK_INDEX_WIDTH'($urandom_range(0, TABLE_DEPTH - 1));
               case ($urandom_range(0, 7))
                  0:       size = '0;
                  1:       size = '1;
                  default: size = FIELD_SIZE_WIDTH'($urandom);
               endcase
            end else begin
               // sizes aimed at a block in use, so most requests land
               op     = OP_REQUEST;
               idx    = BLOCK_INDEX_WIDTH'($urandom);
               target = $urandom_range(0, blocks_in_use() - 1);
               room   = free_space[target];
               case ($urandom_range(0, 9))
                  0:       size = '0;
                  1:       size = room;
                  2, 3:    size = FIELD_SIZE_WIDTH'($urandom);
                  default: size = FIELD_SIZE_WIDTH'($urandom_range(0, room));
               endcase
            end
            issue_transaction(op, idx, size, 1'b0, NONE);
         end
      end

      hold_sender();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions under %0d register settings",
               item_total, setting_count);
      $display("results: %0d allocated, %0d with no fit, %0d loads, %0d mismatches",
               alloc_seen, nofit_seen, load_seen, mismatch_count);
      if (mismatch_count == 0 && expected_placements.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
